@@ rtl/core/tcrd_pkg.sv @@
// Package: shared types, codes and constants of the token coherence root directory.
`default_nettype none
package tcrd_pkg;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int AW = 48;
    localparam int TW = 10;
    localparam int SW = 8;
    localparam int LNW = 48;

    typedef enum logic [2:0] {
        ACT_FWD     = 3'd0,
        ACT_FWD_TOK = 3'd1,
        ACT_MEMRD   = 3'd2,
        ACT_ABSORB  = 3'd3,
        ACT_WB      = 3'd4,
        ACT_RESP    = 3'd5,
        ACT_ERR     = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        PH_EMPTY   = 2'd0,
        PH_LOADING = 2'd1,
        PH_FULL    = 2'd2
    } t_phase;

    localparam logic [2:0] KIND_READ  = 3'd0;
    localparam logic [2:0] KIND_RDATA = 3'd1;
    localparam logic [2:0] KIND_EVICT = 3'd2;

    localparam logic [1:0] REG_LSIZE  = 2'd0;
    localparam logic [1:0] REG_NROOTS = 2'd1;
    localparam logic [1:0] REG_ROOTID = 2'd2;
    localparam logic [1:0] REG_TOTTOK = 2'd3;

    // Classified word passed from front to back
    typedef struct packed {
        logic          func;
        logic [2:0]    kind;
        logic [AW-1:0] addr;
        logic [TW-1:0] tokens;
        logic [SW-1:0] sender;
        logic          dirty;
        logic          local_hit;
        logic [AW-1:0] dest_addr;
    } t_item;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DECIDE,
        BK_OUT
    } t_bk_state;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } t_fr_state;
endpackage
`default_nettype wire

@@ rtl/core/tcrd_front.sv @@
// Front end: accepts words, computes locality and de-striped address by serial division.
`default_nettype none
module tcrd_front
    import tcrd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_func,
    input  wire logic [2:0]    i_msg_kind,
    input  wire logic [AW-1:0] i_line_address,
    input  wire logic [TW-1:0] i_msg_tokens,
    input  wire logic [SW-1:0] i_msg_sender,
    input  wire logic          i_msg_dirty,
    input  wire logic [3:0]    i_lsize,
    input  wire logic [6:0]    i_nroots,
    input  wire logic [5:0]    i_rootid,
    output logic               o_push,
    output t_item              o_item,
    input  wire logic          i_full
);
    t_fr_state r_state, n_state;
    t_item     r_item;
    logic [LNW-1:0] r_quo;
    logic [6:0]     r_rem;
    logic [5:0]     r_cnt;
    logic [6:0]     w_div;
    logic [7:0]     w_trial;
    logic [LNW-1:0] w_line;

    assign w_div  = (i_nroots == 7'd0) ? 7'd1 : i_nroots;
    assign w_line = i_line_address >> i_lsize;
    assign w_trial = {r_rem, r_quo[LNW-1]};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FR_IDLE: if (i_valid) n_state = FR_DIV;
            FR_DIV:  if (r_cnt == 6'd0) n_state = FR_PUSH;
            FR_PUSH: if (!i_full) n_state = FR_IDLE;
            default: n_state = FR_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready = (r_state == FR_IDLE);
        o_push  = (r_state == FR_PUSH) && !i_full;
        o_item  = r_item;
        o_item.local_hit = (r_rem == {1'b0, i_rootid});
        o_item.dest_addr = r_quo << i_lsize;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (r_state == FR_IDLE && i_valid) begin
            r_item.func   <= i_func;
            r_item.kind   <= i_msg_kind;
            r_item.addr   <= i_line_address;
            r_item.tokens <= i_msg_tokens;
            r_item.sender <= i_msg_sender;
            r_item.dirty  <= i_msg_dirty;
            r_item.local_hit <= 1'b0;
            r_item.dest_addr <= '0;
            r_quo <= w_line;
            r_rem <= '0;
            r_cnt <= 6'(LNW - 1);
        end else if (r_state == FR_DIV) begin
            if (w_trial >= {1'b0, w_div}) begin
                r_rem <= 7'(w_trial - {1'b0, w_div});
                r_quo <= {r_quo[LNW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[6:0];
                r_quo <= {r_quo[LNW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/tcrd_queue.sv @@
// Two-entry queue between front and back.
`default_nettype none
module tcrd_queue
    import tcrd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_avail,
    output t_item      o_item
);
    t_item r_mem [2];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_avail)) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
endmodule
`default_nettype wire

@@ rtl/core/tcrd_back.sv @@
// Back end: scans the line table, updates at most one entry and drives the result register.
`default_nettype none
module tcrd_back
    import tcrd_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_avail,
    input  wire t_item         i_item,
    output logic               o_pop,
    input  wire logic [TW-1:0] i_tottok,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [2:0]         o_action,
    output logic [TW-1:0]      o_out_tokens,
    output logic [SW-1:0]      o_out_sender,
    output logic [AW-1:0]      o_mem_address
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_bk_state r_state, n_state;
    t_item     r_it;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [AW-1:0] m_tag   [TABLE_DEPTH];
    logic [1:0]    m_phase [TABLE_DEPTH];
    logic [TW-1:0] m_tok   [TABLE_DEPTH];
    logic [SW-1:0] m_orig  [TABLE_DEPTH];
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_rtag;
    logic [1:0]    r_rph;
    logic [TW-1:0] r_rtok;
    logic [SW-1:0] r_rorig;
    logic          r_rvld;
    logic          r_hit, r_free_ok;
    logic [IW-1:0] r_hit_idx, r_free_idx, r_rd_idx;
    logic [1:0]    r_hph;
    logic [TW-1:0] r_htok;
    logic [SW-1:0] r_horig;
    logic          r_chk;
    logic [IW-1:0] w_idx;
    logic [2:0]    r_act;
    logic [TW-1:0] r_otok;
    logic [SW-1:0] r_osnd;
    logic [AW-1:0] r_oaddr;
    logic          r_ovalid;
    // decision outputs
    logic          d_wr, d_alloc, d_free;
    logic [1:0]    d_ph;
    logic [TW-1:0] d_tok;
    logic [SW-1:0] d_orig;
    logic [IW-1:0] d_widx;
    logic [2:0]    d_act;
    logic [TW-1:0] d_otok;
    logic [SW-1:0] d_osnd;
    logic [AW-1:0] d_oaddr;
    logic [TW:0]   w_sum;
    logic          w_out_free;

    assign w_idx = r_idx[IW-1:0];
    assign w_out_free = !r_ovalid || i_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:   if (i_avail) n_state = BK_SCAN;
            BK_SCAN:   if (r_chk && r_idx == CW'(TABLE_DEPTH)) n_state = BK_DECIDE;
            BK_DECIDE: n_state = BK_OUT;
            BK_OUT:    if (w_out_free) n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    assign o_pop = (r_state == BK_IDLE) && i_avail;

    // Work out the action from the scan result
    always_comb begin
        d_wr = 1'b0; d_alloc = 1'b0; d_free = 1'b0;
        d_widx = r_hit ? r_hit_idx : r_free_idx;
        d_ph = r_hph;
        d_tok = r_htok;
        d_orig = r_horig;
        d_act = ACT_FWD; d_otok = r_it.tokens; d_osnd = r_it.sender; d_oaddr = '0;
        w_sum = {1'b0, r_it.tokens} + {1'b0, r_htok};
        if (r_it.func) begin
            if (r_hit && r_hph == PH_LOADING) begin
                d_wr = 1'b1; d_ph = PH_FULL;
                d_act = ACT_RESP; d_otok = i_tottok;
                d_osnd = r_horig; d_oaddr = r_it.dest_addr;
            end else begin
                d_act = ACT_ERR; d_otok = '0;
            end
        end else if (r_it.local_hit) begin
            priority if (r_it.kind == KIND_READ) begin
                if (!r_hit) begin
                    if (!r_free_ok) begin
                        d_act = ACT_ERR; d_otok = '0;
                    end else begin
                        d_wr = 1'b1; d_alloc = 1'b1; d_ph = PH_LOADING;
                        d_tok = '0; d_orig = r_it.sender;
                        d_act = ACT_MEMRD; d_otok = '0; d_oaddr = r_it.dest_addr;
                    end
                end
            end else if (r_it.kind == KIND_RDATA) begin
                if (!r_hit) begin
                    if (!r_free_ok) begin
                        d_act = ACT_ERR; d_otok = '0;
                    end else begin
                        d_wr = 1'b1; d_alloc = 1'b1; d_ph = PH_FULL;
                        d_tok = '0; d_orig = '0;
                        d_act = ACT_FWD_TOK; d_otok = i_tottok;
                    end
                end else if (r_hph == PH_EMPTY) begin
                    d_wr = 1'b1; d_ph = PH_FULL;
                    d_act = ACT_FWD_TOK; d_otok = i_tottok;
                end else if (r_htok != '0) begin
                    d_wr = 1'b1; d_tok = '0;
                    d_act = ACT_FWD_TOK; d_otok = r_htok;
                end
            end else if (r_it.kind == KIND_EVICT) begin
                if (!r_hit || r_hph != PH_FULL) begin
                    d_act = ACT_ERR; d_otok = '0;
                end else if (w_sum < {1'b0, i_tottok}) begin
                    d_wr = 1'b1; d_tok = w_sum[TW-1:0];
                    d_act = ACT_ABSORB; d_otok = '0;
                end else begin
                    d_free = 1'b1;
                    if (r_it.dirty) begin
                        d_act = ACT_WB; d_oaddr = r_it.dest_addr;
                    end else begin
                        d_act = ACT_ABSORB; d_otok = '0;
                    end
                end
            end else begin
                d_act = ACT_FWD;
            end
        end
    end

    // Outputs
    always_comb begin
        o_valid       = r_ovalid;
        o_action      = r_act;
        o_out_tokens  = r_otok;
        o_out_sender  = r_osnd;
        o_mem_address = r_oaddr;
    end

    // Registered table read, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (r_state == BK_SCAN && r_idx < CW'(TABLE_DEPTH)) begin
            r_rtag <= m_tag[w_idx];
            r_rph  <= m_phase[w_idx];
            r_rtok <= m_tok[w_idx];
            r_rorig <= m_orig[w_idx];
        end
    end

    // Table write
    always_ff @(posedge i_clk) begin
        if (r_state == BK_DECIDE && d_wr) begin
            if (d_alloc) m_tag[d_widx] <= r_it.addr;
            m_phase[d_widx] <= d_ph;
            m_tok[d_widx]   <= d_tok;
            m_orig[d_widx]  <= d_orig;
        end
    end

    // Control and scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
            r_chk    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_chk <= 1'b0;
            end else if (r_state == BK_SCAN) begin
                r_chk <= (r_idx < CW'(TABLE_DEPTH));
            end
            if (r_state == BK_DECIDE) begin
                if (d_wr && d_alloc) r_valid[d_widx] <= 1'b1;
                else if (d_free) r_valid[d_widx] <= 1'b0;
            end
            // Load a new result or drop the one just taken
            if (r_state == BK_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Scan bookkeeping and result register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_it <= i_item;
            r_idx <= '0;
            r_hit <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (r_state == BK_SCAN) begin
            if (r_idx < CW'(TABLE_DEPTH)) begin
                r_idx <= r_idx + CW'(1);
                r_rd_idx <= w_idx;
                r_rvld <= r_valid[w_idx];
            end
            if (r_chk) begin
                if (r_rvld && r_rtag == r_it.addr && !r_hit) begin
                    r_hit <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                    r_hph <= r_rph;
                    r_htok <= r_rtok;
                    r_horig <= r_rorig;
                end
                if (!r_rvld && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
            end
        end
        if (r_state == BK_OUT && w_out_free) begin
            r_act <= d_act; r_otok <= d_otok; r_osnd <= d_osnd; r_oaddr <= d_oaddr;
        end
    end

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_OUT && w_out_free) |=> r_ovalid) else $error("result lost");
    a_act_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_act != 3'd7) else $error("bad action");
    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DECIDE && d_alloc) |-> !r_valid[d_widx])
        else $error("allocating a used entry");
endmodule
`default_nettype wire

@@ rtl/core/token_coherence_root_directory_unit.sv @@
// Top level of the token coherence root directory.
// Input channel i_valid/o_ready carries one word: a ring message (i_func 0) or a memory
// read completion (i_func 1) with kind, line address, tokens, sender and dirty flag.
// Output channel o_valid/i_ready carries one result word per input word: action,
// tokens, sender and de-striped memory address.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (0 line size log2,
// 1 root count, 2 root id, 3 total tokens) at once; write only while idle.
// The front end takes a word and runs a bit-serial division of the line number by
// the root count, giving locality and de-striped address; it takes no new word until
// it has pushed the last one. Words then go through a two-entry queue to the back end,
// which pops a word, scans the line table one entry a cycle, decides, updates at most
// one entry and loads the result register before it pops the next word.
// The front end divides the next word while the back end works on the current one.
// Reset empties the table and loads register defaults; no clearing pass is needed.
// When the receiver stalls the result waits in the output register, the back end holds
// its next result, and the queue and front end go on filling until full.
`default_nettype none
module token_coherence_root_directory_unit
    import tcrd_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [9:0]    i_cfg_data,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_func,
    input  wire logic [2:0]    i_msg_kind,
    input  wire logic [AW-1:0] i_line_address,
    input  wire logic [TW-1:0] i_msg_tokens,
    input  wire logic [SW-1:0] i_msg_sender,
    input  wire logic          i_msg_dirty,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [2:0]         o_action,
    output logic [TW-1:0]      o_out_tokens,
    output logic [SW-1:0]      o_out_sender,
    output logic [AW-1:0]      o_mem_address
);
    logic [3:0]    r_lsize;
    logic [6:0]    r_nroots;
    logic [5:0]    r_rootid;
    logic [TW-1:0] r_tottok;
    logic  w_push, w_full, w_pop, w_avail;
    t_item w_fitem, w_qitem;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsize  <= 4'd6;
            r_nroots <= 7'd1;
            r_rootid <= 6'd0;
            r_tottok <= 10'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LSIZE:  r_lsize  <= i_cfg_data[3:0];
                REG_NROOTS: r_nroots <= i_cfg_data[6:0];
                REG_ROOTID: r_rootid <= i_cfg_data[5:0];
                REG_TOTTOK: r_tottok <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tcrd_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_func, .i_msg_kind, .i_line_address, .i_msg_tokens, .i_msg_sender,
        .i_msg_dirty,
        .i_lsize(r_lsize), .i_nroots(r_nroots), .i_rootid(r_rootid),
        .o_push(w_push), .o_item(w_fitem), .i_full(w_full)
    );

    tcrd_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_item(w_fitem), .o_full(w_full),
        .i_pop(w_pop), .o_avail(w_avail), .o_item(w_qitem)
    );

    tcrd_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_avail(w_avail), .i_item(w_qitem), .o_pop(w_pop),
        .i_tottok(r_tottok), .o_valid, .i_ready,
        .o_action, .o_out_tokens, .o_out_sender, .o_mem_address
    );
endmodule
`default_nettype wire
